// ===== rtl/nearest_neighbor_frame_scaler_defines.svh =====
// Assertion macros shared by the frame scaler RTL.
`ifndef NEAREST_NEIGHBOR_FRAME_SCALER_DEFINES_SVH
`define NEAREST_NEIGHBOR_FRAME_SCALER_DEFINES_SVH

// Same-cycle implication, checked on clk, off during reset
`define NNFS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off during reset
`define NNFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/nnfs_pkg.sv =====
// Types, constants and register map of the nearest-neighbor frame scaler.
package nnfs_pkg;

  // Source frame store
  localparam int STORE_DEPTH = 65536;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Field widths
  localparam int DIM_W    = 13;
  localparam int POS_W    = 12;
  localparam int STRIDE_W = 17;
  localparam int BASE_W   = 26;
  localparam int PIX_W    = 32;
  localparam int IDX_W    = 16;

  // Row times line stride
  localparam int YS_W = POS_W + STRIDE_W;

  // Divider: dividend is pos * size, padded to an even count of bits
  localparam int PROD_W    = POS_W + DIM_W;
  localparam int DVD_W     = PROD_W + (PROD_W % 2);
  localparam int DIV_STEPS = DVD_W / 2;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);

  localparam logic [PIX_W-1:0] ALPHA_FORCE = 32'hff00_0000;

  // Configuration port
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  typedef enum logic [2:0] {
    REG_SRC_WIDTH   = 3'd0,
    REG_SRC_HEIGHT  = 3'd1,
    REG_DST_WIDTH   = 3'd2,
    REG_DST_HEIGHT  = 3'd3,
    REG_LINE_STRIDE = 3'd4,
    REG_PAGE_BASE   = 3'd5
  } reg_idx_t;

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_FETCH = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ADDR,
    ST_READ,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic             func;
    logic [IDX_W-1:0] store_index;
    logic [PIX_W-1:0] store_pixel;
    logic [POS_W-1:0] dest_x;
    logic [POS_W-1:0] dest_y;
  } in_word_t;

  typedef struct packed {
    logic [PIX_W-1:0] color;
    logic [31:0]      dest_offset;
  } out_word_t;

  // Divider request and response
  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DIM_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/nnfs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module nnfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/nnfs_div.sv =====
// Radix-4 restoring divider: two quotient bits per cycle, zero divisor gives 0.
module nnfs_div import nnfs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DVD_W-1:0]  quo_r, quo_nxt;
  logic [DIM_W-1:0]  rem_r, rem_nxt;
  logic [DIM_W-1:0]  dsr_r;
  logic              zero_r;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  logic [DIM_W:0]    t1, t2;
  logic              ge1, ge2;
  logic [DIM_W-1:0]  r1, r2;

  // Two restoring steps; partial remainder stays below the divisor
  always_comb begin
    t1  = {rem_r, quo_r[DVD_W-1]};
    ge1 = t1 >= {1'b0, dsr_r};
    r1  = ge1 ? DIM_W'(t1 - {1'b0, dsr_r}) : t1[DIM_W-1:0];
    t2  = {r1, quo_r[DVD_W-2]};
    ge2 = t2 >= {1'b0, dsr_r};
    r2  = ge2 ? DIM_W'(t2 - {1'b0, dsr_r}) : t2[DIM_W-1:0];
  end

  // Control: load on start, count the steps down
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = STEP_W'(DIV_STEPS);
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
    end else if (busy_r) begin
      rem_nxt = r2;
      quo_nxt = {quo_r[DVD_W-3:0], ge1, ge2};
      cnt_nxt = cnt_r - STEP_W'(1);
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (req.start) begin
      dsr_r  <= req.divisor;
      zero_r <= (req.divisor == '0);
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = zero_r ? '0 : quo_r;

endmodule

// ===== rtl/nearest_neighbor_frame_scaler.sv =====
// Top level of the nearest-neighbor frame scaler: register file, sequencer, store.
//
//  channel  | handshake                    | word
//  ---------+------------------------------+-----------------------------------
//  in       | in_valid / in_stall          | in_data  (func, index, pixel, x, y)
//  out      | out_valid / out_stall        | out_data (color, dest_offset)
//  cfg      | psel / penable / pwrite / ...| 32-bit registers at 4*i
//
// A write word puts the pixel into the store at the accept edge.
// A fetch word holds the input from the accept cycle through DIV_STEPS (13)
// two-bit steps of the row and column dividers and their registered done flags,
// then address, store read and load of the result into the output register.
// The output register holds a result while out_stall is high; a further fetch
// may run meanwhile and waits in its last cycle until that register frees.
// Synchronous active-low reset clears control state; the store is not cleared.
`include "nearest_neighbor_frame_scaler_defines.svh"

module nearest_neighbor_frame_scaler import nnfs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // input words
  input  logic              in_valid,
  output logic              in_stall,
  input  in_word_t          in_data,
  // result words
  output logic              out_valid,
  input  logic              out_stall,
  output out_word_t         out_data,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  // Configuration registers
  logic [DIM_W-1:0]    src_width_r, src_height_r, dst_width_r, dst_height_r;
  logic [STRIDE_W-1:0] line_stride_r;
  logic [BASE_W-1:0]   page_base_r;
  logic                cfg_wr;
  reg_idx_t            cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r   <= DIM_W'(1);
      src_height_r  <= DIM_W'(1);
      dst_width_r   <= DIM_W'(1);
      dst_height_r  <= DIM_W'(1);
      line_stride_r <= STRIDE_W'(4);
      page_base_r   <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SRC_WIDTH:   src_width_r   <= pwdata[DIM_W-1:0];
        REG_SRC_HEIGHT:  src_height_r  <= pwdata[DIM_W-1:0];
        REG_DST_WIDTH:   dst_width_r   <= pwdata[DIM_W-1:0];
        REG_DST_HEIGHT:  dst_height_r  <= pwdata[DIM_W-1:0];
        REG_LINE_STRIDE: line_stride_r <= pwdata[STRIDE_W-1:0];
        REG_PAGE_BASE:   page_base_r   <= pwdata[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (cfg_idx)
      REG_SRC_WIDTH:   prdata = CFG_DW'(src_width_r);
      REG_SRC_HEIGHT:  prdata = CFG_DW'(src_height_r);
      REG_DST_WIDTH:   prdata = CFG_DW'(dst_width_r);
      REG_DST_HEIGHT:  prdata = CFG_DW'(dst_height_r);
      REG_LINE_STRIDE: prdata = CFG_DW'(line_stride_r);
      REG_PAGE_BASE:   prdata = CFG_DW'(page_base_r);
      default:         prdata = '0;
    endcase
  end

  // Sequencer
  state_t state_r, state_nxt;
  logic   in_acc, fetch_acc, write_acc;
  logic   out_free, load_out, ram_re;
  logic   out_valid_r;

  div_req_t req_row, req_col;
  div_rsp_t rsp_row, rsp_col;

  assign in_acc    = in_valid && !in_stall;
  assign fetch_acc = in_acc && (in_data.func == FUNC_FETCH);
  assign write_acc = in_acc && (in_data.func == FUNC_WRITE);
  assign out_free  = !out_valid_r || !out_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (fetch_acc) begin
        state_nxt = ST_DIV;
      end
      ST_DIV:  if (rsp_row.done && rsp_col.done) begin
        state_nxt = ST_ADDR;
      end
      ST_ADDR: state_nxt = ST_READ;
      ST_READ: state_nxt = ST_LOAD;
      ST_LOAD: if (out_free) begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall = 1'b1;
    ram_re   = 1'b0;
    load_out = 1'b0;
    case (state_r)
      ST_IDLE: in_stall = 1'b0;
      ST_READ: ram_re   = 1'b1;
      ST_LOAD: load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Row and column scaling: (pos * src) / dst
  assign req_row.start    = fetch_acc;
  assign req_row.dividend = DVD_W'(in_data.dest_y * src_height_r);
  assign req_row.divisor  = dst_height_r;
  assign req_col.start    = fetch_acc;
  assign req_col.dividend = DVD_W'(in_data.dest_x * src_width_r);
  assign req_col.divisor  = dst_width_r;

  nnfs_div u_div_row (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req_row),
    .rsp   (rsp_row)
  );

  nnfs_div u_div_col (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req_col),
    .rsp   (rsp_col)
  );

  // Fetch payload: x and y * stride captured at accept
  logic [POS_W-1:0]  dest_x_r;
  logic [YS_W-1:0]   ystride_r;
  logic [31:0]       offset_r;
  logic [ADDR_W-1:0] addr_sum;
  logic [ADDR_W-1:0] rd_addr_r;

  // Store address wraps at the depth, so only the low bits are formed
  assign addr_sum = ADDR_W'(rsp_row.quotient) * ADDR_W'(src_width_r)
                  + ADDR_W'(rsp_col.quotient);

  always_ff @(posedge clk) begin
    if (fetch_acc) begin
      dest_x_r  <= in_data.dest_x;
      ystride_r <= YS_W'(in_data.dest_y * line_stride_r);
    end
    if (state_r == ST_ADDR) begin
      rd_addr_r <= addr_sum;
      offset_r  <= 32'(page_base_r) + 32'(ystride_r) + 32'({dest_x_r, 2'b00});
    end
  end

  // Source frame store
  logic [PIX_W-1:0] ram_rdata;

  nnfs_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (write_acc),
    .waddr (ADDR_W'(in_data.store_index)),
    .wdata (in_data.store_pixel),
    .re    (ram_re),
    .raddr (rd_addr_r),
    .rdata (ram_rdata)
  );

  // Output register
  out_word_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r.color       <= ram_rdata | ALPHA_FORCE;
      out_data_r.dest_offset <= offset_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  `NNFS_ASSERT_NOW(a_div_done_in_div, rsp_row.done || rsp_col.done, state_r == ST_DIV, "divider done outside divide phase")
  `NNFS_ASSERT_NOW(a_div_lockstep, state_r == ST_DIV, rsp_row.done == rsp_col.done, "row and column dividers out of step")
  `NNFS_ASSERT_NEXT(a_fetch_starts_div, fetch_acc, state_r == ST_DIV, "accepted fetch did not start division")
  `NNFS_ASSERT_NEXT(a_write_stays_idle, write_acc, state_r == ST_IDLE, "write word left the idle state")
  `NNFS_ASSERT_NEXT(a_load_waits, state_r == ST_LOAD && out_valid_r && out_stall, state_r == ST_LOAD && out_valid_r, "result loaded over a stalled word")

endmodule

// ===== tb/tb_nearest_neighbor_frame_scaler.sv =====
// Self-checking testbench for the nearest-neighbor frame scaler: store writes, scaled fetches, registers.
module tb_nearest_neighbor_frame_scaler;
  import nnfs_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_word_t          in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_word_t         out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  nearest_neighbor_frame_scaler dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Shadow of the register file
  bit [DIM_W-1:0]    src_w, src_h, dst_w, dst_h;
  bit [STRIDE_W-1:0] stride;
  bit [BASE_W-1:0]   base;

  // Shadow of the source frame store, and which entries the stimulus has filled
  bit [PIX_W-1:0] frame_copy [STORE_DEPTH];
  bit             pixel_written [STORE_DEPTH];

  in_word_t  pending_words [$];
  out_word_t expected_pixels [$];

  int  errors = 0;
  int  send_idle_pct = 0;
  int  stall_pct = 0;
  int  hold_reqs = 0;
  int  hold_seen = 0;
  int  hold_left = 0;
  int  words_sent = 0;
  bit  in_took = 1'b0;

  // Source store address of a destination pixel under the current sizes
  function automatic bit [IDX_W-1:0] source_addr(bit [POS_W-1:0] x, bit [POS_W-1:0] y);
    bit [63:0] row, col;
    row = (dst_h == 0) ? 64'd0 : (64'(y) * src_h) / dst_h;
    col = (dst_w == 0) ? 64'd0 : (64'(x) * src_w) / dst_w;
    return IDX_W'(row * src_w + col);
  endfunction

  // Apply one accepted word to the shadow store; a fetch yields one result
  function automatic void track_word(in_word_t w);
    out_word_t due;
    if (w.func == FUNC_WRITE) begin
      frame_copy[w.store_index] = w.store_pixel;
    end else begin
      due.color       = frame_copy[source_addr(w.dest_x, w.dest_y)] | ALPHA_FORCE;
      due.dest_offset = 32'(64'(base) + 64'(w.dest_y) * stride + 64'(w.dest_x) * 4);
      expected_pixels.push_back(due);
    end
  endfunction

  // Input driver: a new word only once the previous one was taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= pending_words.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Input acceptance
  always @(posedge clk) begin
    in_took <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall)
      track_word(in_data);
  end

  // Result stall: random, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= 300;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t unexpected result word: expected none, got %h", $time, out_data);
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        if (out_data.color !== want.color) begin
          $display("%0t color: expected %h, got %h", $time, want.color, out_data.color);
          errors++;
        end
        if (out_data.dest_offset !== want.dest_offset) begin
          $display("%0t dest_offset: expected %h, got %h", $time, want.dest_offset,
                   out_data.dest_offset);
          errors++;
        end
      end
    end
  end

  // Register write followed by a readback
  task automatic reg_write(reg_idx_t r, bit [31:0] v);
    bit [31:0] kept;
    case (r)
      REG_SRC_WIDTH: begin
        src_w = v[DIM_W-1:0]; kept = 32'(src_w);
      end
      REG_SRC_HEIGHT: begin
        src_h = v[DIM_W-1:0]; kept = 32'(src_h);
      end
      REG_DST_WIDTH: begin
        dst_w = v[DIM_W-1:0]; kept = 32'(dst_w);
      end
      REG_DST_HEIGHT: begin
        dst_h = v[DIM_W-1:0]; kept = 32'(dst_h);
      end
      REG_LINE_STRIDE: begin
        stride = v[STRIDE_W-1:0]; kept = 32'(stride);
      end
      REG_PAGE_BASE: begin
        base = v[BASE_W-1:0]; kept = 32'(base);
      end
      default: kept = '0;
    endcase
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= {r, 2'b00}; pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    penable <= 1'b0; pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== kept) begin
      $display("%0t register %0d readback: expected %h, got %h", $time, r, kept, prdata);
      errors++;
    end
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0;
  endtask

  task automatic set_frame(bit [31:0] sw, bit [31:0] sh, bit [31:0] dw, bit [31:0] dh,
                           bit [31:0] ls, bit [31:0] pb);
    reg_write(REG_SRC_WIDTH, sw);
    reg_write(REG_SRC_HEIGHT, sh);
    reg_write(REG_DST_WIDTH, dw);
    reg_write(REG_DST_HEIGHT, dh);
    reg_write(REG_LINE_STRIDE, ls);
    reg_write(REG_PAGE_BASE, pb);
  endtask

  task automatic pace(int send, int recv);
    send_idle_pct = send;
    stall_pct     = recv;
  endtask

  task automatic push_write(bit [IDX_W-1:0] idx, bit [PIX_W-1:0] pix);
    in_word_t w;
    w.func        = FUNC_WRITE;
    w.store_index = idx;
    w.store_pixel = pix;
    w.dest_x      = POS_W'($urandom);
    w.dest_y      = POS_W'($urandom);
    pending_words.push_back(w);
    words_sent++;
    pixel_written[idx] = 1'b1;
  endtask

  // A fetch of a never-written entry is preceded by a write to it
  task automatic push_fetch(bit [POS_W-1:0] x, bit [POS_W-1:0] y);
    in_word_t w;
    bit [IDX_W-1:0] a;
    a = source_addr(x, y);
    if (!pixel_written[a])
      push_write(a, $urandom);
    w.func        = FUNC_FETCH;
    w.store_index = IDX_W'($urandom);
    w.store_pixel = $urandom;
    w.dest_x      = x;
    w.dest_y      = y;
    pending_words.push_back(w);
    words_sent++;
  endtask

  // Wait until every word went in and every result came out, then let the block settle
  task automatic drain();
    int waited;
    waited = 0;
    while ((pending_words.size() != 0 || in_valid || expected_pixels.size() != 0)
           && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (waited >= 20000) begin
      $display("%0t results missing: expected %0d more, got none", $time,
               expected_pixels.size());
      errors++;
      expected_pixels.delete();
      pending_words.delete();
    end
    repeat (40) @(posedge clk);
  endtask

  // Mixed traffic of n words: noise writes, rewrites of visible pixels, fetches in and out of view
  task automatic run_random(int n);
    int r, xr, yr, start_cnt;
    xr = (dst_w == 0) ? 0 : ((dst_w > 4096) ? 4095 : dst_w - 1);
    yr = (dst_h == 0) ? 0 : ((dst_h > 4096) ? 4095 : dst_h - 1);
    start_cnt = words_sent;
    while (words_sent - start_cnt < n) begin
      r = $urandom_range(99);
      if (r < 20)
        push_write(IDX_W'($urandom), $urandom);
      else if (r < 38)
        push_write(source_addr(POS_W'($urandom_range(xr)), POS_W'($urandom_range(yr))),
                   $urandom);
      else if (r < 90)
        push_fetch(POS_W'($urandom_range(xr)), POS_W'($urandom_range(yr)));
      else
        push_fetch(POS_W'($urandom), POS_W'($urandom));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset sizes, before any register write
    src_w = 1; src_h = 1; dst_w = 1; dst_h = 1; stride = 4; base = 0;
    pace(0, 0);
    push_fetch(5, 7);
    push_fetch(4095, 4095);
    drain();

    // Directed: small upscale, alpha forcing, corners and far outside the view
    set_frame(4, 3, 8, 6, 64, 32'h100);
    push_write(0, 32'h0000_0000);
    push_write(11, 32'hffff_ffff);
    for (int i = 1; i < 11; i++)
      push_write(IDX_W'(i), $urandom);
    push_fetch(0, 0);
    push_fetch(7, 5);
    push_fetch(3, 2);
    push_fetch(4095, 4095);
    push_fetch(4095, 0);
    push_fetch(0, 4095);
    push_write(16'hffff, 32'h1234_5678);
    push_write(0, 32'h00a5_5a00);
    push_fetch(0, 0);
    drain();

    // All-ones register writes; long hold-off on results while words keep coming
    set_frame(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
              32'hffff_ffff, 32'hffff_ffff);
    pace(0, 0);
    run_random(150);
    hold_reqs++;
    drain();

    // Zero destination size: row and column pinned to zero
    set_frame(16, 16, 0, 0, 4, 0);
    pace(58, 0);
    run_random(120);
    drain();

    // Heavy downscale, large stride and top page base
    set_frame(4096, 4096, 1, 1, 65536, 32'h3ff_ffff);
    pace(0, 58);
    run_random(150);
    drain();

    // One source pixel blown up to the full destination
    set_frame(1, 1, 4096, 4096, 16384, $urandom);
    pace(34, 34);
    run_random(150);
    drain();

    // Typical 2x upscale
    set_frame(320, 240, 640, 480, 2560, $urandom);
    pace(0, 0);
    run_random(200);
    drain();

    // Random small frames under each idling pattern
    for (int p = 0; p < 3; p++) begin
      set_frame($urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(1, 128),
                $urandom_range(1, 128), $urandom_range(4, 131071), $urandom);
      case (p)
        0: pace(58, 0);
        1: pace(0, 58);
        default: pace(34, 34);
      endcase
      run_random(150);
      drain();
    end

    if (errors == 0) begin
      $display("tb_nearest_neighbor_frame_scaler: clean");
    end else begin
      $display("tb_nearest_neighbor_frame_scaler: errors");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5000000;
    $display("tb_nearest_neighbor_frame_scaler: errors");
    $finish;
  end

endmodule
